/* hw/rtl/scfh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfh_pkg: shared types and constants of the serial command frame handler
// Frame markers, reply layout, result kinds and the front-to-back command.
// ----------------------------------------------------------------------------
package scfh_pkg;

    localparam int MAX_PENDING_BYTES = 18;
    localparam int CNT_W = $clog2(MAX_PENDING_BYTES + 2);

    localparam logic [7:0] END_MARK_A = 8'hFE;
    localparam logic [7:0] END_MARK_B = 8'hFD;

    localparam int FRAME_LEN  = 6;
    localparam int HEAD_LEN   = 4;
    localparam int HEAD_IDX_W = $clog2(HEAD_LEN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // result sequence positions: twelve reply bytes, then the update result
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] RB_ADDR     = 4'd0;
    localparam logic [IDX_W-1:0] RB_SET_HI   = 4'd1;
    localparam logic [IDX_W-1:0] RB_SET_LO   = 4'd2;
    localparam logic [IDX_W-1:0] RB_ANA_HI   = 4'd3;
    localparam logic [IDX_W-1:0] RB_ANA_LO   = 4'd4;
    localparam logic [IDX_W-1:0] RB_BUTTONS  = 4'd5;
    localparam logic [IDX_W-1:0] RB_TEMP     = 4'd6;
    localparam logic [IDX_W-1:0] RB_HUM      = 4'd7;
    localparam logic [IDX_W-1:0] RB_AUX      = 4'd8;
    localparam logic [IDX_W-1:0] RB_CHECKSUM = 4'd9;
    localparam logic [IDX_W-1:0] RB_MARK_A   = 4'd10;
    localparam logic [IDX_W-1:0] RB_MARK_B   = 4'd11;
    localparam logic [IDX_W-1:0] UPDATE_IDX  = 4'd12;

    typedef struct packed {
        logic        do_poll;
        logic        do_set;
        logic [7:0]  address;
        logic [14:0] old_settings;
        logic [14:0] new_settings;
        logic [9:0]  analog;
        logic [3:0]  buttons;
        logic [7:0]  temperature;
        logic [7:0]  humidity;
        logic [3:0]  aux;
        logic [7:0]  checksum;
    } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/scfh_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfh_if: channel interfaces of the serial command frame handler
// Configuration write, received byte request and result channels.
// ----------------------------------------------------------------------------
interface scfh_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;

    modport source (output valid, output device_address, input ready);
    modport sink (input valid, input device_address, output ready);
endinterface

interface scfh_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [9:0] analog_level;
    logic [3:0] button_levels;
    logic [7:0] temperature;
    logic [7:0] humidity;
    logic [3:0] aux_levels;

    modport source (output valid, output rx_byte, output analog_level,
                    output button_levels, output temperature, output humidity,
                    output aux_levels, input ready);
    modport sink (input valid, input rx_byte, input analog_level,
                  input button_levels, input temperature, input humidity,
                  input aux_levels, output ready);
endinterface

interface scfh_tx_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [14:0] settings_word;

    modport source (output valid, output result_kind, output tx_byte,
                    output last, output settings_word, input ready);
    modport sink (input valid, input result_kind, input tx_byte,
                  input last, input settings_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/serial_command_frame_handler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_handler: serial poll and settings frame handler
// Top level joining byte intake, command queue and result sequencer.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle whenever the two-entry command queue
// has room; a byte that completes a valid poll frame yields twelve status
// reply bytes, a valid settings frame one update result, and a frame that is
// both gives thirteen results, reply first. The result sequencer emits one
// result per cycle unless tx.ready stalls it, via a registered output stage,
// while intake runs up to two frames ahead. The user must write the device
// address via the configuration channel only while idle; this is unchecked.
module serial_command_frame_handler
    import scfh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    scfh_cfg_if.sink  cfg,
    scfh_rx_if.sink   rx,
    scfh_tx_if.source tx
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    scfh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .rx     (rx),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    scfh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .cmd_in (q_cmd),
        .pop    (q_pop),
        .full   (q_full),
        .empty  (q_empty),
        .head   (q_head)
    );

    scfh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .tx      (tx)
    );

endmodule
`default_nettype wire

/* hw/rtl/scfh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfh_front: byte intake and frame classification
// Tracks the pending frame, detects end markers, checks poll and settings
// frames and pushes one command per frame that causes results.
// ----------------------------------------------------------------------------
module scfh_front
    import scfh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    scfh_cfg_if.sink    cfg,
    scfh_rx_if.sink     rx,
    input  wire logic   q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [7:0]       addr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       prev_reg;
    logic [7:0]       head_reg [HEAD_LEN];
    logic [14:0]      set_reg;
    logic [14:0]      set_next;

    logic       accept;
    logic       end_seen;
    logic       frame_ok;
    logic       poll;
    logic       set;
    logic [7:0] sum3;
    logic [7:0] sum9;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !q_full;
    assign accept    = rx.valid && rx.ready;

    // previous byte is held in prev_reg, the last byte accepted
    assign end_seen = (cnt_reg != '0) && (rx.rx_byte == END_MARK_B)
                      && (prev_reg == END_MARK_A);
    assign frame_ok = end_seen && (cnt_reg == CNT_W'(FRAME_LEN - 1));

    assign sum3 = head_reg[0] + head_reg[1] + head_reg[2];

    assign poll = frame_ok && (head_reg[0] == addr_reg)
                  && (head_reg[0] == head_reg[1]) && (head_reg[1] == head_reg[2])
                  && (head_reg[2] == head_reg[3]);
    assign set  = frame_ok && (head_reg[0] == addr_reg)
                  && ((8'd0 - sum3) == head_reg[3]);

    assign cnt_inc = cnt_reg + 1'b1;

    always_comb
    begin
        if (end_seen || (cnt_inc > CNT_W'(MAX_PENDING_BYTES)))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_inc;
        end
    end

    assign set_next = set ? {head_reg[1], head_reg[2][6:0]} : set_reg;

    // reply checksum over bytes 0..8, built with the settings before this frame
    assign sum9 = addr_reg + set_reg[14:7] + {1'b0, set_reg[6:0]}
                  + {6'd0, rx.analog_level[9:8]} + rx.analog_level[7:0]
                  + {rx.button_levels, 4'd0} + rx.temperature + rx.humidity
                  + {rx.aux_levels, 4'd0};

    assign q_push = accept && (poll || set);

    always_comb
    begin
        q_cmd.do_poll      = poll;
        q_cmd.do_set       = set;
        q_cmd.address      = addr_reg;
        q_cmd.old_settings = set_reg;
        q_cmd.new_settings = set_next;
        q_cmd.analog       = rx.analog_level;
        q_cmd.buttons      = rx.button_levels;
        q_cmd.temperature  = rx.temperature;
        q_cmd.humidity     = rx.humidity;
        q_cmd.aux          = rx.aux_levels;
        q_cmd.checksum     = 8'd0 - sum9;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            cnt_reg  <= '0;
            prev_reg <= '0;
            set_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                addr_reg <= cfg.device_address;
            end
            if (accept)
            begin
                cnt_reg  <= cnt_next;
                prev_reg <= rx.rx_byte;
                set_reg  <= set_next;
            end
        end
    end

    // only the first four bytes of a frame are stored for the frame checks
    always_ff @(posedge clk)
    begin
        if (accept && (cnt_reg < CNT_W'(HEAD_LEN)))
        begin
            head_reg[cnt_reg[HEAD_IDX_W-1:0]] <= rx.rx_byte;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/scfh_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfh_queue: command queue between intake and result sequencer
// Small first-in first-out buffer of classified frame commands.
// ----------------------------------------------------------------------------
module scfh_queue
    import scfh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t cmd_in,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue fill count did not advance on push");
`endif

endmodule
`default_nettype wire

/* hw/rtl/scfh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfh_back: result sequencer
// Walks the head command through its reply bytes and update result, one
// result per cycle unless tx.ready stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module scfh_back
    import scfh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    scfh_tx_if.source tx
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] sel;
    logic             ov_reg;
    logic             ov_next;
    logic             kind_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [14:0]      word_reg;

    logic        load;
    logic        fin;
    logic        kind;
    logic [7:0]  byte_val;
    logic [14:0] word_val;

    assign load = !q_empty && (!ov_reg || tx.ready);

    // a settings-only command goes straight to the update result
    assign sel  = q_head.do_poll ? idx_reg : UPDATE_IDX;
    assign fin  = ((sel == RB_MARK_B) && !q_head.do_set) || (sel == UPDATE_IDX);
    assign kind = (sel == UPDATE_IDX) ? KIND_UPDATE : KIND_REPLY;
    assign word_val = (kind == KIND_UPDATE) ? q_head.new_settings
                      : q_head.old_settings;

    always_comb
    begin
        case (sel)
            RB_ADDR:     byte_val = q_head.address;
            RB_SET_HI:   byte_val = q_head.old_settings[14:7];
            RB_SET_LO:   byte_val = {1'b0, q_head.old_settings[6:0]};
            RB_ANA_HI:   byte_val = {6'd0, q_head.analog[9:8]};
            RB_ANA_LO:   byte_val = q_head.analog[7:0];
            RB_BUTTONS:  byte_val = {q_head.buttons, 4'd0};
            RB_TEMP:     byte_val = q_head.temperature;
            RB_HUM:      byte_val = q_head.humidity;
            RB_AUX:      byte_val = {q_head.aux, 4'd0};
            RB_CHECKSUM: byte_val = q_head.checksum;
            RB_MARK_A:   byte_val = END_MARK_A;
            RB_MARK_B:   byte_val = END_MARK_B;
            default:     byte_val = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = fin ? '0 : idx_reg + 1'b1;
        end
    end

    assign q_pop   = load && fin;
    assign ov_next = load || (ov_reg && !tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind;
            byte_reg <= byte_val;
            last_reg <= fin;
            word_reg <= word_val;
        end
    end

    assign tx.valid         = ov_reg;
    assign tx.result_kind   = kind_reg;
    assign tx.tx_byte       = byte_reg;
    assign tx.last          = last_reg;
    assign tx.settings_word = word_reg;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= UPDATE_IDX)
        else $error("result index past the update result");

    a_update_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (kind_reg == KIND_UPDATE)) |-> last_reg)
        else $error("update result not marked last");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == '0))
        else $error("result index not cleared after command done");
`endif

endmodule
`default_nettype wire

/* tb/tb_serial_command_frame_handler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_command_frame_handler: self-checking bench of the frame handler
// Drives received bytes, mirrors frame decoding and reply building in a local
// model, and compares every result request against the predicted sequence.
// ----------------------------------------------------------------------------
module tb_serial_command_frame_handler;
    import scfh_pkg::*;

    localparam int ITEMS_PER_PHASE = 25;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LAST_SLOT       = FRAME_LEN - 1;
    localparam int NUM_DIRECTED    = 20;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        last;
        logic [14:0] word;
    } tx_item_t;

    // typed expectation for one directed byte: result count and final word
    typedef struct packed {
        logic        on;
        logic [3:0]  n;
        logic [14:0] word;
    } row_check_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [9:0]  ana;
        logic [3:0]  btn;
        logic [7:0]  tmp;
        logic [7:0]  hum;
        logic [3:0]  aux;
        logic        chk;
        logic [3:0]  n;
        logic [14:0] word;
    } dir_row_t;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // poll at reset address zero, also a settings frame: reply then update
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFE, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFD, 10'd1023, 4'hF, 8'hFF, 8'hFF, 4'hF, 1'b1, 4'd13, 15'h0000},
        // settings frame, bit7 of third byte set and ignored
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFF, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFF, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'h02, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFE, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFD, 10'h2A5, 4'hA, 8'h5C, 8'hC3, 4'h5, 1'b1, 4'd1, 15'h7FFF},
        // end markers on a two-byte frame
        '{8'hFE, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        '{8'hFD, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd0, 15'h0000},
        // poll again, also a settings frame back to zero; reply carries all-ones settings, zero sensors
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0, 15'h0000},
        '{8'h00, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0, 15'h0000},
        '{8'hFE, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0, 15'h0000},
        '{8'hFD, 10'd0, 4'h0, 8'h00, 8'h00, 4'h0, 1'b1, 4'd13, 15'h0000}
    };

    localparam logic [7:0] PHASE_ADDR [NUM_PHASES] = '{
        8'hFF, 8'h40, 8'h00, 8'h80, 8'hC0, 8'h00
    };

    logic clk;
    logic rst_n;

    scfh_cfg_if cfg_ch ();
    scfh_rx_if  rx_ch ();
    scfh_tx_if  tx_ch ();

    serial_command_frame_handler u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // local copy of the block state
    logic [7:0]  frame_bytes [FRAME_LEN];
    int          byte_count;
    logic [14:0] settings_mirror;
    logic [7:0]  address_mirror;

    tx_item_t    tx_due_q [$];
    row_check_t  row_check_q [$];
    logic [7:0]  byte_plan [$];

    int          err_cnt;
    int          quiet_cycles;
    bit          idle_on;
    bit          stall_req;

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decode one received byte, queue the replies and updates it causes
    task automatic frame_decode(input logic [7:0] data, input logic [9:0] ana,
                                input logic [3:0] btn, input logic [7:0] tmp,
                                input logic [7:0] hum, input logic [3:0] aux,
                                output int n_out, output logic [14:0] final_word);
        logic        end_seen;
        logic        do_poll;
        logic        do_set;
        logic [14:0] new_set;
        logic [7:0]  head_sum;
        logic [7:0]  neg_sum;
        logic [7:0]  chk;
        logic [7:0]  rep [RB_ADDR:RB_MARK_B];
        tx_item_t    r;
        int          c;
        c = byte_count;
        end_seen = (c >= 1) && (data == END_MARK_B) &&
                   (frame_bytes[(c - 1 < LAST_SLOT) ? c - 1 : LAST_SLOT] == END_MARK_A);
        frame_bytes[(c < LAST_SLOT) ? c : LAST_SLOT] = data;
        c++;
        do_poll = 1'b0;
        do_set  = 1'b0;
        new_set = settings_mirror;
        if (end_seen)
        begin
            if (c == FRAME_LEN)
            begin
                if (frame_bytes[0] == address_mirror && frame_bytes[1] == frame_bytes[0] &&
                    frame_bytes[2] == frame_bytes[0] && frame_bytes[3] == frame_bytes[0])
                    do_poll = 1'b1;
                head_sum = frame_bytes[0] + frame_bytes[1] + frame_bytes[2];
                neg_sum  = 8'd0 - head_sum;
                if (frame_bytes[0] == address_mirror && neg_sum == frame_bytes[3])
                begin
                    do_set  = 1'b1;
                    new_set = {frame_bytes[1], frame_bytes[2][6:0]};
                end
            end
            c = 0;
        end
        if (c > MAX_PENDING_BYTES)
            c = 0;
        byte_count = c;
        n_out = 0;
        if (do_poll)
        begin
            rep[RB_ADDR]     = address_mirror;
            rep[RB_SET_HI]   = settings_mirror[14:7];
            rep[RB_SET_LO]   = {1'b0, settings_mirror[6:0]};
            rep[RB_ANA_HI]   = {6'd0, ana[9:8]};
            rep[RB_ANA_LO]   = ana[7:0];
            rep[RB_BUTTONS]  = {btn, 4'd0};
            rep[RB_TEMP]     = tmp;
            rep[RB_HUM]      = hum;
            rep[RB_AUX]      = {aux, 4'd0};
            chk = 8'd0;
            for (int i = RB_ADDR; i <= RB_AUX; i++)
                chk = chk + rep[i];
            rep[RB_CHECKSUM] = 8'd0 - chk;
            rep[RB_MARK_A]   = END_MARK_A;
            rep[RB_MARK_B]   = END_MARK_B;
            r.kind = KIND_REPLY;
            r.word = settings_mirror;
            for (int i = RB_ADDR; i <= RB_MARK_B; i++)
            begin
                r.data = rep[i];
                r.last = (i == RB_MARK_B) && !do_set;
                tx_due_q.push_back(r);
                n_out++;
            end
        end
        if (do_set)
        begin
            settings_mirror = new_set;
            r.kind = KIND_UPDATE;
            r.data = 8'h00;
            r.last = 1'b1;
            r.word = new_set;
            tx_due_q.push_back(r);
            n_out++;
        end
        final_word = settings_mirror;
    endtask

    // offer one byte request, with an occasional gap before it
    task automatic drive_byte(input logic [7:0] data, input logic [9:0] ana,
                              input logic [3:0] btn, input logic [7:0] tmp,
                              input logic [7:0] hum, input logic [3:0] aux,
                              input row_check_t rc);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        row_check_q.push_back(rc);
        rx_ch.valid         <= 1'b1;
        rx_ch.rx_byte       <= data;
        rx_ch.analog_level  <= ana;
        rx_ch.button_levels <= btn;
        rx_ch.temperature   <= tmp;
        rx_ch.humidity      <= hum;
        rx_ch.aux_levels    <= aux;
        do
            @(posedge clk);
        while (!rx_ch.ready);
    endtask

    task automatic wait_idle();
        while (tx_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_address(input logic [7:0] addr);
        wait_idle();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.device_address <= addr;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // one byte sequence: mostly good frames, some broken ones, some noise
    task automatic plan_sequence(input logic [7:0] addr);
        int         pick;
        int         len;
        int         pos;
        logic [7:0] b1;
        logic [7:0] b2;
        byte_plan.delete();
        pick = $urandom_range(0, 99);
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
        if (pick < 40)
            byte_plan = {addr, addr, addr, addr, END_MARK_A, END_MARK_B};
        else if (pick < 70)
            byte_plan = {addr, b1, b2, 8'(8'd0 - addr - b1 - b2), END_MARK_A, END_MARK_B};
        else if (pick < 85)
        begin
            if ($urandom_range(0, 1) == 0)
                byte_plan = {addr, addr, addr, addr, END_MARK_A, END_MARK_B};
            else
                byte_plan = {addr, b1, b2, 8'(8'd0 - addr - b1 - b2), END_MARK_A, END_MARK_B};
            pos = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0: byte_plan[pos] = 8'($urandom_range(0, 255));
                1: byte_plan.delete(pos);
                default: byte_plan.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            // noise, long runs overflow the pending count
            len = $urandom_range(1, 22);
            repeat (len)
            begin
                if ($urandom_range(0, 4) == 0)
                    byte_plan.push_back($urandom_range(0, 1) ? END_MARK_A : END_MARK_B);
                else
                    byte_plan.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) != 0)
            begin
                byte_plan.push_back(END_MARK_A);
                byte_plan.push_back(END_MARK_B);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] addr);
        int sent;
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            plan_sequence(addr);
            foreach (byte_plan[i])
            begin
                drive_byte(byte_plan[i], 10'($urandom_range(0, 1023)),
                           4'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), '0);
                sent++;
            end
        end
        rx_ch.valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin
        tx_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stall_req)
            begin
                stall_req = 1'b0;
                tx_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                tx_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        tx_item_t    due;
        row_check_t  rc;
        int          n_out;
        logic [14:0] final_word;
        if (rst_n)
        begin
            if (tx_ch.valid && tx_ch.ready)
            begin
                if (tx_due_q.size() == 0)
                begin
                    $error("unexpected result kind %0d tx_byte %h settings_word %h",
                           tx_ch.result_kind, tx_ch.tx_byte, tx_ch.settings_word);
                    err_cnt++;
                end
                else
                begin
                    due = tx_due_q.pop_front();
                    if (tx_ch.result_kind !== due.kind)
                    begin
                        $error("result_kind expected %0d actual %0d", due.kind,
                               tx_ch.result_kind);
                        err_cnt++;
                    end
                    if (tx_ch.tx_byte !== due.data)
                    begin
                        $error("tx_byte expected %h actual %h", due.data, tx_ch.tx_byte);
                        err_cnt++;
                    end
                    if (tx_ch.last !== due.last)
                    begin
                        $error("last expected %0d actual %0d", due.last, tx_ch.last);
                        err_cnt++;
                    end
                    if (tx_ch.settings_word !== due.word)
                    begin
                        $error("settings_word expected %h actual %h", due.word,
                               tx_ch.settings_word);
                        err_cnt++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                address_mirror = cfg_ch.device_address;
            if (rx_ch.valid && rx_ch.ready)
            begin
                frame_decode(rx_ch.rx_byte, rx_ch.analog_level, rx_ch.button_levels,
                             rx_ch.temperature, rx_ch.humidity, rx_ch.aux_levels,
                             n_out, final_word);
                rc = row_check_q.pop_front();
                if (rc.on && (n_out != rc.n || (n_out != 0 && final_word !== rc.word)))
                begin
                    $error("directed byte results expected %0d word %h, predicted %0d word %h",
                           rc.n, rc.word, n_out, final_word);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tx_ch.valid && tx_ch.ready) || (rx_ch.valid && rx_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("serial_command_frame_handler verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        row_check_t  rc;
        logic [7:0]  addr;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_bytes[i] = 8'h00;
        byte_count      = 0;
        settings_mirror = '0;
        address_mirror  = 8'h00;
        err_cnt         = 0;
        quiet_cycles    = 0;
        idle_on         = 1'b1;
        stall_req       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.device_address = 8'h00;
        rx_ch.valid           = 1'b0;
        rx_ch.rx_byte         = 8'h00;
        rx_ch.analog_level    = 10'd0;
        rx_ch.button_levels   = 4'h0;
        rx_ch.temperature     = 8'h00;
        rx_ch.humidity        = 8'h00;
        rx_ch.aux_levels      = 4'h0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            rc.on   = DIRECTED[i].chk;
            rc.n    = DIRECTED[i].n;
            rc.word = DIRECTED[i].word;
            drive_byte(DIRECTED[i].data, DIRECTED[i].ana, DIRECTED[i].btn,
                       DIRECTED[i].tmp, DIRECTED[i].hum, DIRECTED[i].aux, rc);
        end
        rx_ch.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            addr = (p == 2) ? 8'($urandom_range(1, 254)) : PHASE_ADDR[p];
            set_address(addr);
            // no idling in the middle stretch and at the end of the run
            idle_on = (p != 3) && (p != NUM_PHASES - 1);
            if (p == 1)
                stall_req = 1'b1;
            run_phase(addr);
        end

        wait_idle();
        if (err_cnt == 0)
            $display("serial_command_frame_handler verification clean");
        else
            $display("serial_command_frame_handler verification failed");
        $finish;
    end

endmodule
